FILE: hdl/tmp_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid motion profile package
// Shared types, register indexes and operation codes of the profile block.
// ----------------------------------------------------------------------------
package tmp_pkg;

  typedef struct packed {
    logic signed [63:0] distance_to_go;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] speed_out;
    logic signed [63:0] position_out;
    logic               braking;
  } out_item_t;

  localparam logic [1:0] REG_ACCEL  = 2'd0;
  localparam logic [1:0] REG_CRUISE = 2'd1;
  localparam logic [1:0] REG_MIN    = 2'd2;
  localparam logic [1:0] REG_TARGET = 2'd3;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL
  } op_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

FILE: hdl/tmp_alu.sv
// ----------------------------------------------------------------------------
// Shared multicycle arithmetic unit
// Signed 32-bit truncating divide and wrapping 32-bit multiply, one bit per
// cycle, both run on one shift and add datapath.
// ----------------------------------------------------------------------------
module tmp_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  tmp_pkg::alu_req_t req,
  output tmp_pkg::alu_rsp_t rsp
);
  import tmp_pkg::*;

  logic        busy_r;
  op_t         op_r;
  logic [5:0]  cnt_r;
  logic [31:0] acc_r;
  logic [31:0] x_r;
  logic [31:0] y_r;
  logic        neg_r;
  logic        done_r;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] ua;
  logic [31:0] ub;

  assign ua     = req.a[31] ? (32'd0 - req.a) : req.a;
  assign ub     = req.b[31] ? (32'd0 - req.b) : req.b;
  assign rem_sh = {acc_r[30:0], x_r[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, y_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= 6'd32;
        acc_r  <= '0;
        if (req.op == OP_DIV) begin
          x_r   <= ua;
          y_r   <= ub;
          neg_r <= req.a[31] ^ req.b[31];
        end else begin
          x_r   <= req.a;
          y_r   <= req.b;
          neg_r <= 1'b0;
        end
      end else if (busy_r) begin
        if (op_r == OP_DIV) begin
          if (!trial[32]) begin
            acc_r <= trial[31:0];
            x_r   <= {x_r[30:0], 1'b1};
          end else begin
            acc_r <= rem_sh;
            x_r   <= {x_r[30:0], 1'b0};
          end
        end else begin
          if (y_r[0]) acc_r <= acc_r + x_r;
          x_r <= {x_r[30:0], 1'b0};
          y_r <= {1'b0, y_r[31:1]};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done   = done_r;
    rsp.result = (op_r == OP_DIV) ? (neg_r ? (32'd0 - x_r) : x_r) : acc_r;
  end

endmodule

FILE: hdl/trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// Trapezoid motion profile generator
// Plans one speed and position update per control tick.
// ----------------------------------------------------------------------------
// Each accepted item is one control tick. A tick that needs the braking
// distance runs a divide and two multiplies, one after another, on the one
// shared shift-and-add unit, and the braking distance is evaluated at most
// once per tick. Wrong-direction and overspeed ticks pass through S_CHECK and
// S_INTEG to S_OUT. Restart, zero-step and idle ticks go from S_IDLE straight
// to S_OUT. The block takes no new item until the result of the previous one
// is taken, and it is ready again in the cycle after that.
module trapezoid_motion_profile (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tmp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tmp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import tmp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BD_DIV, S_BD_MUL1, S_BD_MUL2, S_CHECK, S_RUN, S_INTEG, S_SNAP, S_OUT
  } state_t;

  state_t             state_r;
  logic signed [31:0] accel_r, cruise_r, tgt_r, acc_r, speed_r, q_r, tmp_r;
  logic        [30:0] min_r;
  logic signed [63:0] target_r, dist_r, pos_r, bd_r;
  logic               brake_r, in_run_r;
  alu_req_t           req;
  alu_rsp_t           rsp;
  logic               started_r;

  tmp_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic signed [31:0] lim, n_add, n_sub, mag, bd_raw;
  logic signed [63:0] absd;
  logic               bd_ge_d;

  assign lim     = {1'b0, min_r};
  assign n_add   = speed_r + acc_r;
  assign n_sub   = speed_r - acc_r;
  assign mag     = accel_r[31] ? (32'sd0 - accel_r) : accel_r;
  assign absd    = dist_r[63] ? (64'sd0 - dist_r) : dist_r;
  assign bd_ge_d = bd_r >= absd;

  always_comb begin
    logic signed [31:0] half;
    half = rsp.result;
    half = (half >>> 1) + ((half[31] && half[0]) ? 32'sd1 : 32'sd0);
    if (acc_r > 0) begin
      if (half < 0) half = 0;
    end else if (speed_r == 0 || half > 0) half = 0;
    if (half < 0) half = 32'sd0 - half;
    bd_raw = half;
  end

  // A step's start request is registered in started_r before it reaches the shared unit.
  always_comb begin
    req       = '0;
    req.start = started_r;
    unique case (state_r)
      S_BD_DIV: begin
        req.op = OP_DIV;
        req.a  = speed_r;
        req.b  = acc_r;
      end
      S_BD_MUL1: begin
        req.op = OP_MUL;
        req.a  = q_r;
        req.b  = acc_r;
      end
      default: begin
        req.op = OP_MUL;
        req.a  = q_r;
        req.b  = (speed_r + speed_r) - (acc_r + tmp_r);
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = '{speed_out: speed_r, position_out: pos_r, braking: brake_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      accel_r   <= '0;
      cruise_r  <= '0;
      min_r     <= '0;
      target_r  <= '0;
      speed_r   <= '0;
      pos_r     <= '0;
      brake_r   <= 1'b0;
    end else begin
      started_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ACCEL:  accel_r  <= cfg_data[31:0];
          REG_CRUISE: cruise_r <= cfg_data[31:0];
          REG_MIN:    min_r    <= cfg_data[30:0];
          REG_TARGET: target_r <= cfg_data;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dist_r <= in_data.distance_to_go;
            tgt_r  <= in_data.distance_to_go[63] ? (32'sd0 - cruise_r) : cruise_r;
            acc_r  <= in_data.distance_to_go[63] ? (32'sd0 - accel_r) : accel_r;
            if (in_data.restart) begin
              speed_r <= '0;
              pos_r   <= '0;
              brake_r <= 1'b0;
              state_r <= S_OUT;
            end else if (in_data.distance_to_go == 0 || cruise_r == 0) begin
              if (mag == 0 || speed_r == 0) speed_r <= '0;
              else if (speed_r > 0) begin
                speed_r <= ($unsigned(speed_r) <= $unsigned(mag)) ? 32'sd0 : speed_r - mag;
              end else begin
                speed_r <= ($unsigned(32'sd0 - speed_r) <= $unsigned(mag)) ?
                           32'sd0 : speed_r + mag;
              end
              state_r <= S_OUT;
            end else begin
              in_run_r <= brake_r;
              state_r  <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // Wrong-direction and overspeed cases need no braking distance.
          if (!in_run_r && speed_r < 0 && tgt_r > 0) begin
            speed_r <= (n_add >= -lim) ? 32'sd0 : n_add;
            state_r <= S_INTEG;
          end else if (!in_run_r && !(speed_r < 1 || tgt_r > -1)) begin
            speed_r <= (lim < n_add) ? n_add : 32'sd0;
            state_r <= S_INTEG;
          end else if (acc_r == 0 || (acc_r > 0 && speed_r < 0) ||
                       (acc_r < 0 && speed_r > 0)) begin
            bd_r    <= '0;
            state_r <= in_run_r ? S_RUN : S_SNAP;
          end else begin
            started_r <= 1'b1;
            state_r   <= S_BD_DIV;
          end
        end
        S_BD_DIV: begin
          if (rsp.done) begin
            q_r <= (speed_r == 32'h8000_0000 && acc_r == -1) ? 32'h8000_0000 : rsp.result;
            started_r <= 1'b1;
            state_r   <= S_BD_MUL1;
          end
        end
        S_BD_MUL1: begin
          if (rsp.done) begin
            tmp_r     <= rsp.result;
            started_r <= 1'b1;
            state_r   <= S_BD_MUL2;
          end
        end
        S_BD_MUL2: begin
          if (rsp.done) begin
            bd_r    <= {{32{1'b0}}, bd_raw};
            state_r <= in_run_r ? S_RUN : S_SNAP;
          end
        end
        S_SNAP: begin
          // Braking check of the not-yet-braking phase.
          if (absd >= bd_r) begin
            brake_r  <= 1'b1;
            in_run_r <= 1'b1;
            state_r  <= S_RUN;
          end else begin
            if ((n_sub < lim && tgt_r > 0) || (-lim < n_sub && tgt_r < 0)) speed_r <= '0;
            else speed_r <= n_sub;
            state_r <= S_INTEG;
          end
        end
        S_RUN: begin
          begin
            logic signed [31:0] s, an, at;
            logic signed [63:0] p;
            s  = speed_r;
            at = tgt_r[31] ? (32'sd0 - tgt_r) : tgt_r;
            an = n_add[31] ? (32'sd0 - n_add) : n_add;
            if (bd_ge_d) s = n_sub;
            else if (speed_r != tgt_r) s = (at < an) ? tgt_r : n_add;
            if (tgt_r > 0 && s < lim) s = lim;
            if (tgt_r < 0 && -lim < s) s = -lim;
            p = pos_r + {{32{s[31]}}, s};
            if ((tgt_r < 0 && p <= target_r) || (tgt_r >= 0 && p >= target_r && tgt_r > 0)) begin
              pos_r   <= target_r;
              speed_r <= '0;
            end else begin
              pos_r   <= p;
              speed_r <= s;
            end
          end
          state_r <= S_OUT;
        end
        S_INTEG: begin
          pos_r   <= pos_r + {{32{speed_r[31]}}, speed_r};
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
